// File: hdl/itrs_pkg.sv
// Shared constants, command/status types and character helpers for the radix string converter.
package itrs_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 32;

	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;

	localparam logic [6:0] CHAR_NUL    = 7'h00;
	localparam logic [6:0] CHAR_MINUS  = 7'h2D;
	localparam logic [6:0] CHAR_ZERO   = 7'h30;
	localparam logic [6:0] CHAR_NINE   = 7'h39;
	localparam logic [6:0] CHAR_UPPERA = 7'h41;
	localparam logic [6:0] CHAR_UPPERZ = 7'h5A;

	typedef struct packed {
		logic load;
		logic div_step;
		logic load_err;
		logic load_minus;
		logic fetch;
		logic load_digit;
	} itrs_cmd_t;

	typedef struct packed {
		logic bad_radix;
		logic last_step;
		logic conv_done;
		logic negative;
		logic dig_zero;
		logic out_free;
	} itrs_sts_t;

	// digit value 0..35 to ASCII
	function automatic logic [6:0] digit_char(input logic [5:0] d);
		logic [6:0] c;
		if (d < 6'd10) begin
			c = CHAR_ZERO + {1'b0, d};
		end else begin
			c = CHAR_UPPERA + {1'b0, d} - 7'd10;
		end
		return c;
	endfunction

	// floor(log2(radix)): bits the quotient loses at each digit
	function automatic logic [2:0] radix_log2(input logic [5:0] r);
		logic [2:0] l;
		case (r) inside
			[6'd2:6'd3]:   l = 3'd1;
			[6'd4:6'd7]:   l = 3'd2;
			[6'd8:6'd15]:  l = 3'd3;
			[6'd16:6'd31]: l = 3'd4;
			[6'd32:6'd63]: l = 3'd5;
			default:       l = 3'd1;
		endcase
		return l;
	endfunction

endpackage

// File: hdl/itrs_dpath.sv
// Datapath: magnitude register, bit-serial divider by the radix, digit store and output register.
module itrs_dpath import itrs_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [5:0]             radix,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [6:0]             character,
	output logic                   last,
	output logic                   bad_radix,
	input  itrs_cmd_t              cmd,
	output itrs_sts_t              sts
);

	localparam int IW = $clog2(VALUE_WIDTH);
	localparam int BW = $clog2(VALUE_WIDTH + 1);
	localparam int AW = $clog2(MAX_DIGITS);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [5:0]             rem_q;
	logic [5:0]             radix_q;
	logic                   neg_q;
	logic [IW-1:0]          idx_q;
	logic [BW-1:0]          bits_q;
	logic [AW-1:0]          dig_q;
	logic [5:0]             rdata_q;
	logic                   out_valid_q;
	logic [6:0]             char_q;
	logic                   last_q;
	logic                   bad_q;

	logic [5:0] store_mem [MAX_DIGITS];

	logic [6:0]             trial;
	logic                   ge;
	logic [5:0]             rem_next;
	logic [VALUE_WIDTH-1:0] quo_next;
	logic [2:0]             lg;
	logic [BW-1:0]          bits_next;
	logic                   last_step;
	logic                   conv_done;
	logic                   out_free;

	// one restoring-division step per cycle, MSB first
	assign trial     = {rem_q, mag_q[idx_q]};
	assign ge        = trial >= {1'b0, radix_q};
	assign rem_next  = ge ? 6'(trial - {1'b0, radix_q}) : trial[5:0];
	assign quo_next  = {quo_q[VALUE_WIDTH-2:0], ge};
	assign lg        = radix_log2(radix_q);
	assign bits_next = (bits_q > BW'(lg)) ? BW'(bits_q - BW'(lg)) : BW'(1);
	assign last_step = idx_q == '0;
	assign conv_done = (quo_next == '0) || (dig_q == AW'(MAX_DIGITS - 1));
	assign out_free  = !out_valid_q || out_ready;

	assign sts.bad_radix = !(radix inside {[RADIX_MIN:RADIX_MAX]});
	assign sts.last_step = last_step;
	assign sts.conv_done = conv_done;
	assign sts.negative  = neg_q;
	assign sts.dig_zero  = dig_q == '0;
	assign sts.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= radix;
			neg_q   <= value[VALUE_WIDTH-1];
			mag_q   <= value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~value + 1'b1) : value;
			quo_q   <= '0;
			rem_q   <= '0;
			idx_q   <= IW'(VALUE_WIDTH - 1);
			bits_q  <= BW'(VALUE_WIDTH);
			dig_q   <= '0;
		end else if (cmd.div_step) begin
			if (last_step) begin
				// digit complete: quotient becomes the next dividend
				mag_q  <= quo_next;
				quo_q  <= '0;
				rem_q  <= '0;
				bits_q <= bits_next;
				idx_q  <= IW'(bits_next - BW'(1));
				if (!conv_done) begin
					dig_q <= dig_q + 1'b1;
				end
			end else begin
				quo_q <= quo_next;
				rem_q <= rem_next;
				idx_q <= idx_q - 1'b1;
			end
		end else if (cmd.load_digit) begin
			dig_q <= dig_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && last_step) begin
			store_mem[dig_q] <= rem_next;
		end
		if (cmd.fetch) begin
			rdata_q <= store_mem[dig_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_err || cmd.load_minus || cmd.load_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			char_q <= CHAR_NUL;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end else if (cmd.load_minus) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (cmd.load_digit) begin
			char_q <= digit_char(rdata_q);
			last_q <= dig_q == '0;
			bad_q  <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;
	assign bad_radix = bad_q;

endmodule

// File: hdl/itrs_ctrl.sv
// Controller: sequences accept, digit division, sign and character emission.
module itrs_ctrl import itrs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  itrs_sts_t sts,
	output itrs_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ERR   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_FETCH = 3'd4;
	localparam logic [2:0] ST_SHOW  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.bad_radix ? ST_ERR : ST_DIV;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.load_err = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.last_step && sts.conv_done) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (!sts.negative) begin
					state_d = ST_FETCH;
				end else if (sts.out_free) begin
					cmd.load_minus = 1'b1;
					state_d        = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_SHOW;
			end
			ST_SHOW: begin
				if (sts.out_free) begin
					cmd.load_digit = 1'b1;
					state_d        = sts.dig_zero ? ST_IDLE : ST_FETCH;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/integer_to_radix_string.sv
// Top level of the integer to radix string converter.
//
//  channel | signals                                  | dir | beat
//  --------+------------------------------------------+-----+----------------------------------
//  in      | in_valid, in_ready, value, radix         | in  | one integer and its base
//  out     | out_valid, out_ready, character, last,   | out | one ASCII character, or one error
//          | bad_radix                                |     | beat for a radix outside 2..36
//
// One item at a time. After the accept, the divider works on each digit over B quotient bits,
// one quotient bit per cycle, where B starts at VALUE_WIDTH and drops by floor(log2 radix)
// after every digit, never below 1. Then the sign state loads '-' for a negative value,
// and each digit goes through a digit store read, then an output register load; a bad radix
// goes through the error state, which loads the error beat.
// Reset clears the controller and the output valid; the digit store is not cleared.
// A stalled output holds its beat; conversion pauses only while the output register is full.
module integer_to_radix_string import itrs_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [5:0]             radix,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [6:0]             character,
	output logic                   last,
	output logic                   bad_radix
);

	itrs_cmd_t cmd;
	itrs_sts_t sts;

	itrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itrs_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.radix     (radix),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.character (character),
		.last      (last),
		.bad_radix (bad_radix),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: hdl/itrs_checker.sv
// Port-level checks for the radix string converter, bound to the top level.
module itrs_checker import itrs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] character,
	input logic       last,
	input logic       bad_radix
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last)
			&& $stable(bad_radix))
		else $error("output beat changed while stalled");

	// one item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a conversion runs");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_radix |-> last && (character == CHAR_NUL))
		else $error("error beat malformed");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == CHAR_MINUS) |-> !last && !bad_radix)
		else $error("sign ends a run");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_radix |-> (character == CHAR_MINUS)
			|| (character >= CHAR_ZERO && character <= CHAR_NINE)
			|| (character >= CHAR_UPPERA && character <= CHAR_UPPERZ))
		else $error("character outside digit set");

endmodule

bind integer_to_radix_string itrs_checker u_itrs_checker (.*);

// File: test/integer_to_radix_string_tb.sv
// Self-checking testbench for integer_to_radix_string: directed table then random items.
module integer_to_radix_string_tb import itrs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int    RANDOM_ITEMS = 450;
	localparam int    STALL_LIMIT  = 5000;
	localparam int    TAIL_CYCLES  = 600;
	localparam int    ROWS         = 25;
	localparam string GLYPHS       = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	typedef struct packed {
		logic [6:0] character;
		logic       last;
		logic       bad_radix;
	} glyph_beat_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_BAD} row_kind_t;

	typedef struct {
		logic [31:0] value;
		logic [5:0]  radix;
		row_kind_t   kind;
		string       text;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] value = '0;
	logic [5:0]  radix = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  character;
	logic        last;
	logic        bad_radix;

	glyph_beat_t expected_glyphs[$];
	stim_row_t   stim_table[ROWS];
	int          beat_mismatches = 0;
	int          idle_cycles = 0;
	int          ready_hold = 0;
	bit          steady = 1'b0;

	integer_to_radix_string u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.radix     (radix),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last),
		.bad_radix (bad_radix)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void predict_glyphs(input logic [31:0] v, input logic [5:0] r);
		logic [5:0]  digits[32];
		logic [31:0] mag;
		logic [7:0]  glyph;
		int          n;
		if (r < RADIX_MIN || r > RADIX_MAX) begin
			expected_glyphs.push_back('{CHAR_NUL, 1'b1, 1'b1});
			return;
		end
		// two's complement negate in 32 bits keeps 2^31 exact as unsigned
		mag = v[31] ? (~v + 32'd1) : v;
		n = 0;
		do begin
			digits[n] = 6'(mag % {26'd0, r});
			mag = mag / {26'd0, r};
			n++;
		end while (mag != 0 && n < 32);
		if (v[31]) begin
			expected_glyphs.push_back('{CHAR_MINUS, 1'b0, 1'b0});
		end
		for (int i = n - 1; i >= 0; i--) begin
			glyph = GLYPHS[digits[i]];
			expected_glyphs.push_back('{glyph[6:0], i == 0, 1'b0});
		end
	endfunction

	function automatic void push_typed_text(input string text);
		logic [7:0] glyph;
		for (int i = 0; i < text.len(); i++) begin
			glyph = text[i];
			expected_glyphs.push_back('{glyph[6:0], i == text.len() - 1, 1'b0});
		end
	endfunction

	// called at a rising edge; returns at the edge that takes the beat
	task automatic send_item(input logic [31:0] v, input logic [5:0] r, input row_kind_t kind,
			input string text, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		radix    <= r;
		do @(posedge clk); while (!(in_valid && in_ready));
		case (kind)
			ROW_TEXT: push_typed_text(text);
			ROW_BAD:  expected_glyphs.push_back('{CHAR_NUL, 1'b1, 1'b1});
			default:  predict_glyphs(v, r);
		endcase
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_glyphs.size() != 0) @(posedge clk);
	endtask

	function automatic logic [5:0] random_radix();
		case ($urandom_range(0, 9))
			0: return 6'($urandom_range(0, 63));
			1: begin
				case ($urandom_range(0, 3))
					0: return RADIX_MIN;
					1: return 6'd10;
					2: return 6'd16;
					default: return RADIX_MAX;
				endcase
			end
			default: return 6'($urandom_range(2, 36));
		endcase
	endfunction

	function automatic logic [31:0] random_value(input logic [5:0] r);
		longint p;
		int     k;
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			1, 2: begin
				v = $urandom_range(0, 200);
				if ($urandom_range(0, 1)) v = -v;
			end
			3: begin
				// near a power of the radix, where the digit count steps
				p = 1;
				k = $urandom_range(1, 31);
				if (r >= RADIX_MIN) begin
					repeat (k) if (p * r <= 64'h7FFF_FFFF) p = p * r;
				end
				v = 32'(p) + 32'($urandom_range(0, 2)) - 32'd1;
				if ($urandom_range(0, 1)) v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// output side: check each beat, then pick ready for the next cycle
	always @(posedge clk) begin
		glyph_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_glyphs.size() == 0) begin
				$error("unexpected beat: character %h last %b bad_radix %b",
					character, last, bad_radix);
				beat_mismatches++;
			end else begin
				want = expected_glyphs.pop_front();
				if (character !== want.character) begin
					$error("character: expected %h, got %h", want.character, character);
					beat_mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					beat_mismatches++;
				end
				if (bad_radix !== want.bad_radix) begin
					$error("bad_radix: expected %b, got %b", want.bad_radix, bad_radix);
					beat_mismatches++;
				end
			end
		end
		if (ready_hold > 0) begin
			ready_hold = ready_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0) ready_hold = idle_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] v;
		logic [5:0]  r;
		stim_table = '{
			'{32'd0,          6'd10,           ROW_TEXT,    "0"},
			'{32'd0,          RADIX_MIN,       ROW_TEXT,    "0"},
			'{32'h8000_0000,  6'd10,           ROW_TEXT,    "-2147483648"},
			'{32'h7FFF_FFFF,  6'd10,           ROW_TEXT,    "2147483647"},
			'{32'h7FFF_FFFF,  RADIX_MIN,       ROW_PREDICT, ""},
			'{32'h8000_0000,  RADIX_MIN,       ROW_PREDICT, ""},
			'{32'hFFFF_FFFF,  6'd16,           ROW_TEXT,    "-1"},
			'{32'h7FFF_FFFF,  RADIX_MAX,       ROW_TEXT,    "ZIK0ZJ"},
			'{32'h8000_0000,  RADIX_MAX,       ROW_TEXT,    "-ZIK0ZK"},
			'{32'h8000_0000,  6'd16,           ROW_TEXT,    "-80000000"},
			'{32'h7FFF_FFFF,  6'd16,           ROW_TEXT,    "7FFFFFFF"},
			'{32'd35,         RADIX_MAX,       ROW_TEXT,    "Z"},
			'{-32'sd35,       RADIX_MAX,       ROW_TEXT,    "-Z"},
			'{32'd36,         RADIX_MAX,       ROW_TEXT,    "10"},
			'{32'd9,          6'd10,           ROW_TEXT,    "9"},
			'{32'd10,         6'd16,           ROW_TEXT,    "A"},
			'{32'd1,          RADIX_MIN,       ROW_TEXT,    "1"},
			'{32'd5,          6'd0,            ROW_BAD,     ""},
			'{32'hFFFF_FFFF,  6'd1,            ROW_BAD,     ""},
			'{32'd77,         RADIX_MAX + 6'd1, ROW_BAD,    ""},
			'{32'h8000_0000,  6'd63,           ROW_BAD,     ""},
			'{32'd123456789,  6'd7,            ROW_PREDICT, ""},
			'{-32'sd987654321, 6'd3,           ROW_PREDICT, ""},
			'{32'hDEAD_BEEF,  6'd31,           ROW_PREDICT, ""},
			'{32'h5555_5555,  6'd32,           ROW_PREDICT, ""}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			send_item(stim_table[i].value, stim_table[i].radix, stim_table[i].kind,
				stim_table[i].text, idle_gap());
		end

		// hold the sender until the directed results are all out
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) drain_results();
			steady = (n >= 300 && n < 340);
			r = random_radix();
			v = random_value(r);
			send_item(v, r, ROW_PREDICT, "", steady ? 0 : idle_gap());
		end
		in_valid <= 1'b0;
		steady = 1'b0;

		while (expected_glyphs.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (beat_mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/itrs_pkg.sv
hdl/itrs_dpath.sv
hdl/itrs_ctrl.sv
hdl/integer_to_radix_string.sv
hdl/itrs_checker.sv
test/integer_to_radix_string_tb.sv
